### hdl/bbx_pkg.sv
`timescale 1ns / 1ps

package bbx_pkg;

  // Defaults for the top-level parameters
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_PIXEL_BITS = 8;

  // Configuration register widths and reset values
  localparam int CFG_DATA_W = 13;
  localparam int WIDTH_W    = 11;
  localparam int HEIGHT_W   = 13;
  localparam int ROW_W      = 12;

  localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd8;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 13'd8;
  localparam logic [HEIGHT_W-1:0] HEIGHT_MAX   = 13'd4096;

  // Configuration register indexes
  typedef enum logic {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_e;

  // Pipeline advance strobes handed to the datapath
  typedef struct packed {
    logic acc;   // word accepted, line buffer read issued
    logic adv1;  // stage 1 moves into the window
    logic adv2;  // window column sums move into the sum register
    logic adv3;  // sum moves through the divider into the output register
  } pipe_en_t;

endpackage

### hdl/box_blur_3x3_core.sv
`timescale 1ns / 1ps

// 3x3 box blur on a raster-order grayscale stream.
// Input channel: pixel_in_i with in_valid_i / in_stall_o; a word is taken on
// a rising edge with in_valid_i high and in_stall_o low. Output channel:
// blurred_pixel_o and end_of_frame_o with out_valid_o / out_stall_i.
// Only interior positions (one pixel in from every border) give a result;
// the result for center (r-1, c-1) leaves when pixel (r, c) has gone in.
// end_of_frame_o marks the result caused by the last pixel of the frame.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i
// (image width, image height) and restarts the frame; write only when idle.
// Width is clamped to 3..MAX_WIDTH, height to 3..4096.
// Throughput: one pixel per clock while out_stall_i stays low. A result is
// registered in turn by the line buffer read, the window load, the sum and
// the divide-by-nine multiply into the output register.
// A stalled receiver holds the output register; the four stages fill their
// bubbles first and in_stall_o rises only when all of them are full.
// Reset clears the position counters and pipeline valids and sets both
// dimensions to 8; line buffer contents are left as they are.
module box_blur_3x3_core #(
  parameter int MAX_WIDTH  = bbx_pkg::DEF_MAX_WIDTH,
  parameter int PIXEL_BITS = bbx_pkg::DEF_PIXEL_BITS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic                           cfg_idx_i,
  input  logic [bbx_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [PIXEL_BITS-1:0]          pixel_in_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [PIXEL_BITS-1:0]          blurred_pixel_o,
  output logic                           end_of_frame_o
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = bbx_pkg::ROW_W;

  logic [bbx_pkg::WIDTH_W-1:0]  width_q;
  logic [bbx_pkg::HEIGHT_W-1:0] height_q;
  logic [CW-1:0]                col_q;
  logic [RW-1:0]                row_q;
  logic [CW-1:0]                w_last;
  logic [RW-1:0]                h_last;

  logic v1_q, v2_q, v3_q, vo_q;
  logic prod1_q;
  logic eof1_q, eof2_q, eof3_q, eofo_q;
  logic [CW-1:0]         col1_q;
  logic [PIXEL_BITS-1:0] px1_q;

  logic f1, f2, f3, fo;
  logic accept;
  bbx_pkg::pipe_en_t en;

  logic [PIXEL_BITS-1:0] lb_up;
  logic [PIXEL_BITS-1:0] lb_mid;
  logic [PIXEL_BITS-1:0] cell_top [4];
  logic [PIXEL_BITS-1:0] cell_mid [4];
  logic [PIXEL_BITS-1:0] cell_bot [4];
  logic [PIXEL_BITS+1:0] colsum   [3];

  // Clamp the configured dimensions to last column and last row
  always_comb begin
    if (width_q < 11'd3) begin
      w_last = CW'(2);
    end else if (32'(width_q) >= MAX_WIDTH) begin
      w_last = CW'(MAX_WIDTH - 1);
    end else begin
      w_last = CW'(width_q - 11'd1);
    end
  end

  always_comb begin
    if (height_q < 13'd3) begin
      h_last = RW'(2);
    end else if (height_q >= bbx_pkg::HEIGHT_MAX) begin
      h_last = RW'(bbx_pkg::HEIGHT_MAX - 13'd1);
    end else begin
      h_last = RW'(height_q - 13'd1);
    end
  end

  // Advance each stage when the next one is free or moving on
  assign fo       = !vo_q || !out_stall_i;
  assign f3       = !v3_q || fo;
  assign f2       = !v2_q || f3;
  assign f1       = !v1_q || f2;
  assign accept   = in_valid_i && f1;
  assign en.acc   = accept;
  assign en.adv1  = v1_q && f2;
  assign en.adv2  = v2_q && f3;
  assign en.adv3  = v3_q && fo;
  assign in_stall_o = !f1;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= bbx_pkg::WIDTH_RESET;
      height_q <= bbx_pkg::HEIGHT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bbx_pkg::REG_IMAGE_WIDTH:  width_q  <= cfg_data_i[bbx_pkg::WIDTH_W-1:0];
        bbx_pkg::REG_IMAGE_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Position counters: restart on a register write, wrap at frame end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (cfg_we_i) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      if (col_q == w_last) begin
        col_q <= '0;
        row_q <= (row_q == h_last) ? '0 : row_q + RW'(1);
      end else begin
        col_q <= col_q + CW'(1);
      end
    end
  end

  // Pipeline valids and frame flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      vo_q    <= 1'b0;
      prod1_q <= 1'b0;
      eof1_q  <= 1'b0;
      eof2_q  <= 1'b0;
      eof3_q  <= 1'b0;
      eofo_q  <= 1'b0;
    end else begin
      if (accept) begin
        v1_q    <= 1'b1;
        prod1_q <= (row_q >= RW'(2)) && (col_q >= CW'(2));
        eof1_q  <= (row_q == h_last) && (col_q == w_last);
      end else if (en.adv1) begin
        v1_q <= 1'b0;
      end
      if (en.adv1) begin
        v2_q   <= prod1_q;
        eof2_q <= eof1_q;
      end else if (en.adv2) begin
        v2_q <= 1'b0;
      end
      if (en.adv2) begin
        v3_q   <= 1'b1;
        eof3_q <= eof2_q;
      end else if (en.adv3) begin
        v3_q <= 1'b0;
      end
      if (en.adv3) begin
        vo_q   <= 1'b1;
        eofo_q <= eof3_q;
      end else if (fo) begin
        vo_q <= 1'b0;
      end
    end
  end

  // Hold the pixel and its column while the line buffer read completes
  always_ff @(posedge clk_i) begin
    if (accept) begin
      px1_q  <= pixel_in_i;
      col1_q <= col_q;
    end
  end

  bbx_lbuf #(
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_lbuf (
    .clk_i     (clk_i),
    .rd_en_i   (en.acc),
    .rd_addr_i (col_q),
    .wr_en_i   (en.adv1),
    .wr_addr_i (col1_q),
    .wr_px_i   (px1_q),
    .up_o      (lb_up),
    .mid_o     (lb_mid)
  );

  // Window: three column cells, newest on the right, shifting left
  assign cell_top[3] = lb_up;
  assign cell_mid[3] = lb_mid;
  assign cell_bot[3] = px1_q;

  for (genvar k = 0; k < 3; k++) begin : g_cell
    bbx_col_cell #(
      .PIXEL_BITS (PIXEL_BITS)
    ) u_cell (
      .clk_i    (clk_i),
      .en_i     (en.adv1),
      .top_i    (cell_top[k+1]),
      .mid_i    (cell_mid[k+1]),
      .bot_i    (cell_bot[k+1]),
      .top_o    (cell_top[k]),
      .mid_o    (cell_mid[k]),
      .bot_o    (cell_bot[k]),
      .colsum_o (colsum[k])
    );
  end

  bbx_mean #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_mean (
    .clk_i  (clk_i),
    .en_i   (en),
    .col0_i (colsum[0]),
    .col1_i (colsum[1]),
    .col2_i (colsum[2]),
    .mean_o (blurred_pixel_o)
  );

  assign out_valid_o    = vo_q;
  assign end_of_frame_o = eofo_q;

  // Input stalls only when every stage holds a word
  a_stall_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (v1_q && v2_q && v3_q && vo_q))
    else $error("input stalled with a free pipeline stage");

  // An accepted word always lands in stage 1
  a_accept_loads : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> v1_q)
    else $error("accepted word lost before stage 1");

  // Counters stay inside the clamped frame
  a_col_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_q <= w_last)
    else $error("column counter beyond last column");

  a_row_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_q <= h_last)
    else $error("row counter beyond last row");

  // The frame end position is always an interior one
  a_eof_interior : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && eof1_q) |-> prod1_q)
    else $error("end of frame flagged on a border position");

endmodule

### hdl/bbx_lbuf.sv
`timescale 1ns / 1ps

module bbx_lbuf #(
  parameter int MAX_WIDTH  = bbx_pkg::DEF_MAX_WIDTH,
  parameter int PIXEL_BITS = bbx_pkg::DEF_PIXEL_BITS,
  localparam int AW = $clog2(MAX_WIDTH)
) (
  input  logic                  clk_i,
  input  logic                  rd_en_i,
  input  logic [AW-1:0]         rd_addr_i,
  input  logic                  wr_en_i,
  input  logic [AW-1:0]         wr_addr_i,
  input  logic [PIXEL_BITS-1:0] wr_px_i,
  output logic [PIXEL_BITS-1:0] up_o,
  output logic [PIXEL_BITS-1:0] mid_o
);

  logic [PIXEL_BITS-1:0] upper_mem [MAX_WIDTH];
  logic [PIXEL_BITS-1:0] middle_mem [MAX_WIDTH];
  logic [PIXEL_BITS-1:0] rd_up_q;
  logic [PIXEL_BITS-1:0] rd_mid_q;

  // Read both rows at the column of the incoming word
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_up_q  <= upper_mem[rd_addr_i];
      rd_mid_q <= middle_mem[rd_addr_i];
    end
  end

  // Push the column up: middle row moves to upper, new pixel into middle
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      upper_mem[wr_addr_i]  <= rd_mid_q;
      middle_mem[wr_addr_i] <= wr_px_i;
    end
  end

  assign up_o  = rd_up_q;
  assign mid_o = rd_mid_q;

endmodule

### hdl/bbx_col_cell.sv
`timescale 1ns / 1ps

module bbx_col_cell #(
  parameter int PIXEL_BITS = bbx_pkg::DEF_PIXEL_BITS
) (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic [PIXEL_BITS-1:0] top_i,
  input  logic [PIXEL_BITS-1:0] mid_i,
  input  logic [PIXEL_BITS-1:0] bot_i,
  output logic [PIXEL_BITS-1:0] top_o,
  output logic [PIXEL_BITS-1:0] mid_o,
  output logic [PIXEL_BITS-1:0] bot_o,
  output logic [PIXEL_BITS+1:0] colsum_o
);

  logic [PIXEL_BITS-1:0] top_q;
  logic [PIXEL_BITS-1:0] mid_q;
  logic [PIXEL_BITS-1:0] bot_q;
  logic [PIXEL_BITS+1:0] colsum_d;
  logic [PIXEL_BITS+1:0] colsum_q;

  // Sum the incoming column so the window total needs only three terms
  assign colsum_d = (PIXEL_BITS+2)'(top_i) + (PIXEL_BITS+2)'(mid_i)
                  + (PIXEL_BITS+2)'(bot_i);

  // Load the column from the right-hand neighbor
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      top_q    <= top_i;
      mid_q    <= mid_i;
      bot_q    <= bot_i;
      colsum_q <= colsum_d;
    end
  end

  assign top_o    = top_q;
  assign mid_o    = mid_q;
  assign bot_o    = bot_q;
  assign colsum_o = colsum_q;

endmodule

### hdl/bbx_mean.sv
`timescale 1ns / 1ps

module bbx_mean #(
  parameter int PIXEL_BITS = bbx_pkg::DEF_PIXEL_BITS
) (
  input  logic                  clk_i,
  input  bbx_pkg::pipe_en_t     en_i,
  input  logic [PIXEL_BITS+1:0] col0_i,
  input  logic [PIXEL_BITS+1:0] col1_i,
  input  logic [PIXEL_BITS+1:0] col2_i,
  output logic [PIXEL_BITS-1:0] mean_o
);

  // Nine pixels fit in four extra bits; the reciprocal keeps the error
  // well under one ninth, so the product gives the exact floor
  localparam int SUM_W = PIXEL_BITS + 4;
  localparam int SHIFT = SUM_W + 4;
  localparam logic [SHIFT-1:0] RECIP = SHIFT'(((64'd1 << SHIFT) + 64'd8) / 64'd9);

  logic [SUM_W-1:0]       sum_d;
  logic [SUM_W-1:0]       sum_q;
  logic [SUM_W+SHIFT-1:0] prod;
  logic [PIXEL_BITS-1:0]  mean_q;

  assign sum_d = SUM_W'(col0_i) + SUM_W'(col1_i) + SUM_W'(col2_i);

  // Register the window total
  always_ff @(posedge clk_i) begin
    if (en_i.adv2) begin
      sum_q <= sum_d;
    end
  end

  // Divide by nine through the reciprocal
  assign prod = (SUM_W+SHIFT)'(sum_q) * (SUM_W+SHIFT)'(RECIP);

  always_ff @(posedge clk_i) begin
    if (en_i.adv3) begin
      mean_q <= prod[SHIFT +: PIXEL_BITS];
    end
  end

  assign mean_o = mean_q;

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int PIX_W        = bbx_pkg::DEF_PIXEL_BITS;
  localparam int MAX_W        = bbx_pkg::DEF_MAX_WIDTH;
  localparam int CFG_W        = bbx_pkg::CFG_DATA_W;
  localparam int CLK_HALF     = 2;
  localparam int PIPE_SETTLE  = 8;
  localparam int RANDOM_ITEMS = 120;

  typedef struct packed {
    logic [PIX_W-1:0] mean;
    logic             last;
  } mean_word_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic                  cfg_idx_i;
  logic [CFG_W-1:0]      cfg_data_i;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic [PIX_W-1:0]      pixel_in_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic [PIX_W-1:0]      blurred_pixel_o;
  logic                  end_of_frame_o;

  // Mirror of the filter state, advanced on every accepted pixel
  logic [bbx_pkg::WIDTH_W-1:0]  dim_width;
  logic [bbx_pkg::HEIGHT_W-1:0] dim_height;
  logic [PIX_W-1:0]    row_two_up [MAX_W];
  logic [PIX_W-1:0]    row_one_up [MAX_W];
  logic [PIX_W-1:0]    win_px [9];
  int unsigned         pix_col;
  int unsigned         pix_row;
  mean_word_t          pending_means [$];

  int unsigned fail_count       = 0;
  int unsigned send_gap_max     = 0;
  int unsigned recv_gap_max     = 0;
  int unsigned sink_hold_cycles = 0;

  box_blur_3x3_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .pixel_in_i     (pixel_in_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .blurred_pixel_o(blurred_pixel_o),
    .end_of_frame_o (end_of_frame_o)
  );

  always #(CLK_HALF) clk_i = ~clk_i;

  function automatic int unsigned eff_width();
    if (dim_width < 3) return 3;
    if (dim_width > MAX_W) return MAX_W;
    return 32'(dim_width);
  endfunction

  function automatic int unsigned eff_height();
    if (dim_height < 3) return 3;
    if (dim_height > bbx_pkg::HEIGHT_MAX) return 32'(bbx_pkg::HEIGHT_MAX);
    return 32'(dim_height);
  endfunction

  // Advance the window by one pixel and queue the mean it yields, if any
  function automatic void mean_filter_step(input logic [PIX_W-1:0] px);
    int unsigned w, h, c, r, sum;
    mean_word_t word;
    w = eff_width();
    h = eff_height();
    c = (pix_col >= w) ? 0 : pix_col;
    r = (pix_row >= h) ? 0 : pix_row;
    // slide the window one column left, load the new column
    for (int k = 0; k < 3; k++) begin
      win_px[k*3]   = win_px[k*3+1];
      win_px[k*3+1] = win_px[k*3+2];
    end
    win_px[2] = row_two_up[c];
    win_px[5] = row_one_up[c];
    win_px[8] = px;
    row_two_up[c] = row_one_up[c];
    row_one_up[c] = px;
    // interior positions only
    if (r >= 2 && c >= 2) begin
      sum = 0;
      for (int k = 0; k < 9; k++) sum += win_px[k];
      word.mean = PIX_W'(sum / 9);
      word.last = (r == h - 1) && (c == w - 1);
      pending_means.push_back(word);
    end
    // advance position, wrap at row and frame end
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    pix_col = c;
    pix_row = r;
  endfunction

  function automatic logic [PIX_W-1:0] draw_pixel();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return PIX_W'($urandom);
    endcase
  endfunction

  // Write one dimension register; a write restarts the frame
  task automatic write_dim(input bbx_pkg::cfg_reg_e idx, input logic [CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == bbx_pkg::REG_IMAGE_WIDTH) dim_width = val[bbx_pkg::WIDTH_W-1:0];
    else dim_height = val;
    pix_col = 0;
    pix_row = 0;
  endtask

  // Offer one pixel word after a random gap and hold it until taken
  task automatic push_pixel(input logic [PIX_W-1:0] px);
    int unsigned gap;
    gap = $urandom_range(0, send_gap_max);
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    pixel_in_i <= px;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    mean_filter_step(px);
  endtask

  task automatic stream_pixels(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) push_pixel(draw_pixel());
  endtask

  // Drop valid and wait until every queued mean has come out
  task automatic hold_until_empty();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_means.size() != 0) @(negedge clk_i);
  endtask

  // Border pixels give nothing, so let the pipe run dry before going on
  task automatic settle_idle();
    hold_until_empty();
    repeat (PIPE_SETTLE) @(negedge clk_i);
  endtask

  // Reset dimensions of 8x8, with one partial frame after the wrap
  task automatic test_default_frame();
    send_gap_max = 4;
    recv_gap_max = 4;
    stream_pixels(64 + 20);
    settle_idle();
  endtask

  // 3x3 frames: one mean per frame, always flagged as the last
  task automatic test_smallest_frame();
    send_gap_max = 0;
    recv_gap_max = 0;
    write_dim(bbx_pkg::REG_IMAGE_WIDTH, 3);
    write_dim(bbx_pkg::REG_IMAGE_HEIGHT, 3);
    // all at full scale
    repeat (9) push_pixel('1);
    // sum of 17 truncates to 1
    push_pixel(8);
    push_pixel(9);
    repeat (7) push_pixel('0);
    // sum of 2294 truncates to 254
    push_pixel(254);
    repeat (8) push_pixel('1);
    settle_idle();
  endtask

  // Dimensions below three act as three
  task automatic test_low_clamp();
    send_gap_max = 2;
    recv_gap_max = 2;
    write_dim(bbx_pkg::REG_IMAGE_WIDTH, 0);
    write_dim(bbx_pkg::REG_IMAGE_HEIGHT, 0);
    stream_pixels(18);
    settle_idle();
    write_dim(bbx_pkg::REG_IMAGE_WIDTH, 2);
    write_dim(bbx_pkg::REG_IMAGE_HEIGHT, 2);
    stream_pixels(9);
    settle_idle();
    write_dim(bbx_pkg::REG_IMAGE_WIDTH, 4);
    write_dim(bbx_pkg::REG_IMAGE_HEIGHT, 1);
    stream_pixels(12);
    settle_idle();
  endtask

  // All-ones width: the first row stays open past any small width
  task automatic test_wide_rows();
    send_gap_max = 1;
    recv_gap_max = 1;
    write_dim(bbx_pkg::REG_IMAGE_WIDTH, '1);
    write_dim(bbx_pkg::REG_IMAGE_HEIGHT, 3);
    stream_pixels(30);
    settle_idle();
  endtask

  // All-ones height: rows keep going past the reset height
  task automatic test_tall_frame();
    send_gap_max = 0;
    recv_gap_max = 0;
    write_dim(bbx_pkg::REG_IMAGE_WIDTH, 3);
    write_dim(bbx_pkg::REG_IMAGE_HEIGHT, '1);
    stream_pixels(3 * 15);
    settle_idle();
  endtask

  // Long output stall with the input kept busy, then a mid-frame pause
  task automatic test_backpressure();
    send_gap_max = 0;
    recv_gap_max = 0;
    write_dim(bbx_pkg::REG_IMAGE_WIDTH, 6);
    write_dim(bbx_pkg::REG_IMAGE_HEIGHT, 6);
    sink_hold_cycles = 200;
    stream_pixels(72);
    stream_pixels(22);
    hold_until_empty();
    stream_pixels(14);
    settle_idle();
  endtask

  // Mostly whole frames of random pixels, some cut short or paused
  task automatic test_random_frames();
    int unsigned sent, frame_len, n;
    logic fresh;
    sent  = 0;
    fresh = 1'b1;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 3))
        0: begin
          send_gap_max = 0;
          recv_gap_max = 0;
        end
        1: begin
          send_gap_max = 16;
          recv_gap_max = 0;
        end
        2: begin
          send_gap_max = 0;
          recv_gap_max = 16;
        end
        default: begin
          send_gap_max = 16;
          recv_gap_max = 16;
        end
      endcase
      // new dimensions now and then out of range low; skipping both keeps the frame going
      if (fresh || $urandom_range(0, 3) != 0) begin
        write_dim(bbx_pkg::REG_IMAGE_WIDTH,
                  CFG_W'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 2)
                                                     : $urandom_range(3, 12)));
      end
      if (fresh || $urandom_range(0, 3) != 0) begin
        write_dim(bbx_pkg::REG_IMAGE_HEIGHT,
                  CFG_W'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 2)
                                                     : $urandom_range(3, 8)));
      end
      fresh = 1'b0;
      frame_len = eff_width() * eff_height();
      if ($urandom_range(0, 4) == 0) n = $urandom_range(1, frame_len - 1);
      else n = frame_len * $urandom_range(1, 2);
      // stay within the item budget
      if (n > RANDOM_ITEMS - sent) n = RANDOM_ITEMS - sent;
      if ($urandom_range(0, 3) == 0) begin
        stream_pixels(n / 2);
        hold_until_empty();
        stream_pixels(n - n / 2);
      end else begin
        stream_pixels(n);
      end
      sent += n;
      settle_idle();
    end
  endtask

  // Output side: random stall before each word, or a long one on request
  initial begin : sink
    int unsigned hold;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (sink_hold_cycles != 0) begin
        hold = sink_hold_cycles;
        sink_hold_cycles = 0;
      end else begin
        hold = $urandom_range(0, recv_gap_max);
      end
      @(negedge clk_i);
      out_stall_i <= (hold != 0);
      if (hold != 0) begin
        repeat (hold) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  // Compare each word taken from the output with the oldest queued mean
  always @(posedge clk_i) begin : result_check
    mean_word_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_means.size() == 0) begin
        $error("blurred_pixel %0d arrived with nothing pending", blurred_pixel_o);
        fail_count++;
      end else begin
        want = pending_means.pop_front();
        if (blurred_pixel_o !== want.mean) begin
          $error("blurred_pixel: expected %0d, got %0d", want.mean, blurred_pixel_o);
          fail_count++;
        end
        if (end_of_frame_o !== want.last) begin
          $error("end_of_frame: expected %0d, got %0d", want.last, end_of_frame_o);
          fail_count++;
        end
      end
    end
  end

  initial begin : watchdog
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    rst_ni     = 1'b0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = bbx_pkg::REG_IMAGE_WIDTH;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    pixel_in_i = '0;
    dim_width  = bbx_pkg::WIDTH_RESET;
    dim_height = bbx_pkg::HEIGHT_RESET;
    pix_col    = 0;
    pix_row    = 0;
    for (int k = 0; k < 9; k++) win_px[k] = '0;
    for (int k = 0; k < MAX_W; k++) begin
      row_two_up[k] = '0;
      row_one_up[k] = '0;
    end
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_default_frame();
    test_smallest_frame();
    test_low_clamp();
    test_wide_rows();
    test_tall_frame();
    test_backpressure();
    test_random_frames();
    settle_idle();

    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### sim.f
hdl/bbx_pkg.sv
hdl/bbx_lbuf.sv
hdl/bbx_col_cell.sv
hdl/bbx_mean.sv
hdl/box_blur_3x3_core.sv
bench/tb_top.sv
